// File: rtl/core/row_box_filter_full_unit_macros.svh
// Assertion macros used by the row box filter top level.
`ifndef ROW_BOX_FILTER_FULL_UNIT_MACROS_SVH
`define ROW_BOX_FILTER_FULL_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define RBF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("row box filter: same-cycle check failed");

// next-cycle implication
`define RBF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("row box filter: next-cycle check failed");

`endif

// File: rtl/core/rbf_pkg.sv
// Shared widths and constants for the row box filter.
`default_nettype none
package rbf_pkg;
  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 23;
  localparam int WL_W     = 6;
  localparam int MAG_W    = 21;
  localparam int RECIP_K  = 27;
  localparam int RECIP_W  = RECIP_K + 1;
  localparam int PROD_W   = MAG_W + RECIP_W;
  localparam int RCNT_W   = $clog2(RECIP_K);
endpackage
`default_nettype wire

// File: rtl/core/rbf_recip.sv
// Serial reciprocal unit: recip = ceil(2^K / divisor), one quotient bit per cycle.
`default_nettype none
module rbf_recip (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [rbf_pkg::WL_W-1:0]      divisor,
  output logic                               busy,
  output logic [rbf_pkg::RECIP_W-1:0]        recip
);
  logic [rbf_pkg::RCNT_W-1:0]   cnt;
  logic [rbf_pkg::WL_W:0]       rem;
  logic [rbf_pkg::RECIP_K-1:0]  quot;
  logic [rbf_pkg::WL_W:0]       trial;
  logic                         qbit;
  logic [rbf_pkg::WL_W:0]       rem_next;
  logic [rbf_pkg::RECIP_K-1:0]  quot_next;

  // dividend is 2^K - 1, so every shifted-in bit is a one
  always_comb begin
    trial     = {rem[rbf_pkg::WL_W-1:0], 1'b1};
    qbit      = (trial >= {1'b0, divisor});
    rem_next  = qbit ? (trial - {1'b0, divisor}) : trial;
    quot_next = {quot[rbf_pkg::RECIP_K-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rem  <= '0;
    end else if (busy) begin
      rem  <= rem_next;
      quot <= quot_next;
      cnt  <= cnt + 1'b1;
      if (cnt == rbf_pkg::RCNT_W'(rbf_pkg::RECIP_K - 1)) begin
        busy  <= 1'b0;
        recip <= {1'b0, quot_next} + 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/row_box_filter_full_unit.sv
// Top level: full-convolution box filter along one image row.
//
//  channel | signals                      | payload
//  --------+------------------------------+------------------------------------
//  cfg     | cfg_valid cfg_ready cfg_data | window_length [5:0]
//  input   | s_tvalid s_tready            | s_tdata sample [15:0], s_tlast last
//  output  | m_tvalid m_tready            | m_tdata average [15:0], m_tlast done
//
//  One sample request at a time: accept, delay line read, sum update, reciprocal
//  multiply, sign fix; the average is offered in S_OUT after S_SUM, S_MUL and S_FIX.
//  A last sample is followed by n-1 drain outputs (n is window_length clamped to
//  1..MAX_WINDOW), each passing S_SUM, S_MUL, S_FIX again and held by any output
//  stall. After reset and after each cfg write the reciprocal unit runs with both
//  ready signals low. Row state clears on the row's final output and on a cfg write.
`default_nettype none
module row_box_filter_full_unit #(
  parameter int MAX_WINDOW = 63
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [rbf_pkg::WL_W-1:0]       cfg_data,  // [5:0] window_length
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [rbf_pkg::SAMPLE_W-1:0]   s_tdata,   // [15:0] sample
  input  wire logic                           s_tlast,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [rbf_pkg::SAMPLE_W-1:0]        m_tdata,   // [15:0] average
  output logic                                m_tlast
);
`include "row_box_filter_full_unit_macros.svh"

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam logic [rbf_pkg::WL_W-1:0] MAX_N = rbf_pkg::WL_W'(MAX_WINDOW);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SUM  = 5'b00010,
    S_MUL  = 5'b00100,
    S_FIX  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t                                 state;
  logic [rbf_pkg::WL_W-1:0]               window_length;
  logic [AW-1:0]                          pos;
  logic [MAX_WINDOW-1:0]                  valid_bits;
  logic signed [rbf_pkg::SUM_W-1:0]       window_sum;
  logic signed [rbf_pkg::SAMPLE_W-1:0]    cur_val;
  logic signed [rbf_pkg::SAMPLE_W-1:0]    rd_data;
  logic                                   old_ok;
  logic                                   last_flag;
  logic [rbf_pkg::WL_W-1:0]               drain_left;
  logic [rbf_pkg::PROD_W-1:0]             prod;
  logic                                   sum_neg;
  logic [rbf_pkg::SAMPLE_W-1:0]           average;
  logic [rbf_pkg::SAMPLE_W-1:0]           mem [MAX_WINDOW];

  logic [rbf_pkg::WL_W-1:0]               n;
  logic [rbf_pkg::WL_W-1:0]               p1;
  logic [AW-1:0]                          pos_next;
  logic signed [rbf_pkg::SUM_W-1:0]       old_term;
  logic signed [rbf_pkg::SUM_W-1:0]       sum_next;
  logic [rbf_pkg::SUM_W-1:0]              mag;
  logic [rbf_pkg::SAMPLE_W-1:0]           quo;
  logic                                   recip_busy;
  logic [rbf_pkg::RECIP_W-1:0]            recip;
  logic                                   cfg_fire;
  logic                                   in_fire;
  logic                                   out_fire;
  logic                                   drain_more;
  logic                                   rd_en;

  rbf_recip u_recip (
    .clk     (clk),
    .rst     (rst),
    .start   (cfg_fire),
    .divisor (n),
    .busy    (recip_busy),
    .recip   (recip)
  );

  always_comb begin
    if (window_length == '0) n = rbf_pkg::WL_W'(1);
    else if (window_length > MAX_N) n = MAX_N;
    else n = window_length;
    p1       = rbf_pkg::WL_W'(pos) + 1'b1;
    pos_next = (p1 >= n) ? '0 : AW'(p1);
    old_term = old_ok ? rbf_pkg::SUM_W'(rd_data) : '0;
    sum_next = window_sum + rbf_pkg::SUM_W'(cur_val) - old_term;
    mag      = sum_neg ? (-window_sum) : window_sum;
    quo      = prod[rbf_pkg::RECIP_K +: rbf_pkg::SAMPLE_W];
  end

  assign cfg_ready  = (state == S_IDLE) && !recip_busy;
  assign s_tready   = (state == S_IDLE) && !recip_busy && !cfg_valid;
  assign m_tvalid   = (state == S_OUT);
  assign m_tdata    = average;
  assign m_tlast    = last_flag && (drain_left == '0);
  assign cfg_fire   = cfg_valid && cfg_ready;
  assign in_fire    = s_tvalid && s_tready;
  assign out_fire   = m_tvalid && m_tready;
  assign drain_more = last_flag && (drain_left != '0);
  assign rd_en      = in_fire || (out_fire && drain_more);

  // delay line memory, registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[pos];
      old_ok  <= valid_bits[pos];
    end
    if (state == S_SUM) mem[pos] <= cur_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window_length <= rbf_pkg::WL_W'(1);
      pos           <= '0;
      valid_bits    <= '0;
      window_sum    <= '0;
      last_flag     <= 1'b0;
      drain_left    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_fire) begin
            window_length <= cfg_data;
            pos           <= '0;
            valid_bits    <= '0;
            window_sum    <= '0;
          end else if (in_fire) begin
            cur_val    <= s_tdata;
            last_flag  <= s_tlast;
            drain_left <= s_tlast ? (n - 1'b1) : '0;
            state      <= S_SUM;
          end
        end
        S_SUM: begin
          window_sum      <= sum_next;
          sum_neg         <= sum_next[rbf_pkg::SUM_W-1];
          valid_bits[pos] <= 1'b1;
          pos             <= pos_next;
          state           <= S_MUL;
        end
        S_MUL: begin
          prod  <= rbf_pkg::PROD_W'(mag[rbf_pkg::MAG_W-1:0]) * rbf_pkg::PROD_W'(recip);
          state <= S_FIX;
        end
        S_FIX: begin
          average <= sum_neg ? (-quo) : quo;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (out_fire) begin
            if (drain_more) begin
              cur_val    <= '0;
              drain_left <= drain_left - 1'b1;
              state      <= S_SUM;
            end else begin
              if (last_flag) begin
                pos        <= '0;
                valid_bits <= '0;
                window_sum <= '0;
              end
              last_flag <= 1'b0;
              state     <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RBF_ASSERT_IMP(a_one_side, s_tready, !m_tvalid && !recip_busy)
  `RBF_ASSERT_NXT(a_row_clear, out_fire && m_tlast, (window_sum == '0) && (pos == '0))
  `RBF_ASSERT_IMP(a_pos_range, state == S_IDLE, rbf_pkg::WL_W'(pos) < n)
  `RBF_ASSERT_IMP(a_drain_range, state == S_OUT, drain_left < n)
  `RBF_ASSERT_NXT(a_cfg_busy, cfg_fire, recip_busy && !s_tready)

endmodule
`default_nettype wire
